// File: hw/rtl/majority_id_finder_assert.svh
// Assertion macros for the majority identifier finder.
// Expects i_clk and i_rst_n in the scope of the using module.
`ifndef MAJORITY_ID_FINDER_ASSERT_SVH
`define MAJORITY_ID_FINDER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define MAJ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("majority_id_finder: check failed");

// Next-cycle implication, quiet during reset.
`define MAJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("majority_id_finder: check failed");

`endif

// File: hw/rtl/maj_pkg.sv
// Shared types and constants of the majority identifier finder.
// No dependencies.
`timescale 1ns / 1ps

package maj_pkg;

    localparam int CODE_W      = 25;
    localparam int OUT_CNT_W   = 16;
    localparam int SHARE_W     = 17;
    localparam int FRAC_BITS   = 16;
    localparam logic [SHARE_W-1:0] SHARE_ONE = 17'h10000;

    typedef logic signed [CODE_W-1:0] t_code;
    typedef logic [OUT_CNT_W-1:0]     t_out_cnt;
    typedef logic [SHARE_W-1:0]       t_share;

    // Status of the fraction divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: hw/rtl/maj_if.sv
// Handshake channels of the majority identifier finder: item in, result out.
// Depends on maj_pkg.
`timescale 1ns / 1ps

interface maj_in_if;
    logic              valid;
    logic              ready;
    maj_pkg::t_code    particle_code;
    logic              last_item;

    modport source (output valid, particle_code, last_item, input ready);
    modport sink   (input valid, particle_code, last_item, output ready);
endinterface

interface maj_out_if;
    logic              valid;
    logic              ready;
    maj_pkg::t_code    mode_code;
    maj_pkg::t_out_cnt mode_count;
    maj_pkg::t_out_cnt total_count;
    maj_pkg::t_share   mode_share;
    logic              table_overflow;

    modport source (output valid, mode_code, mode_count, total_count, mode_share,
                    table_overflow, input ready);
    modport sink   (input valid, mode_code, mode_count, total_count, mode_share,
                    table_overflow, output ready);
endinterface

// File: hw/rtl/majority_id_finder.sv
// Majority identifier finder: running mode of an identifier stream and its share.
// Depends on maj_pkg, maj_if (maj_in_if, maj_out_if), maj_mem, maj_div and
// majority_id_finder_assert.svh.
//
//   port      dir  beat contents                                     ends a set
//   i_item    in   particle_code (25b signed), last_item             last_item = 1
//   o_result  out  mode_code, mode_count, total_count, mode_share,   every beat
//                  table_overflow
//
// A beat is written straight into entry zero when the table is empty; otherwise the
// table memory is scanned one entry per cycle until a match or the last entry in use.
// A last beat adds a mode scan over the entries in use, a serial divide (launch,
// COUNT_BITS + 16 quotient bits, done) and a load of the output register. Reset
// (synchronous, active low) empties the set; the table memory needs no clearing since
// only filled entries are read.
// A stalled result sits in the output register; new beats are taken meanwhile, and the
// next set holds in the load step until that result is taken.
`timescale 1ns / 1ps
`include "majority_id_finder_assert.svh"

module majority_id_finder #(
    parameter int DISTINCT_ENTRIES = 16,
    parameter int COUNT_BITS       = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    maj_in_if.sink     i_item,
    maj_out_if.source  o_result
);

    localparam int ADDR_W   = (DISTINCT_ENTRIES > 1) ? $clog2(DISTINCT_ENTRIES) : 1;
    localparam int ENT_W    = $clog2(DISTINCT_ENTRIES + 1);
    localparam int MEM_W    = maj_pkg::CODE_W + COUNT_BITS;
    localparam int NUM_W    = COUNT_BITS + maj_pkg::FRAC_BITS;
    localparam int WIDE_W   = (COUNT_BITS > maj_pkg::OUT_CNT_W) ? COUNT_BITS
                                                                 : maj_pkg::OUT_CNT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WIDE_W-1:0]     OUT_MAX   = WIDE_W'({maj_pkg::OUT_CNT_W{1'b1}});

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // take a beat
    localparam logic [2:0] ST_CMP    = 3'd1;  // search the table for the code
    localparam logic [2:0] ST_MSTART = 3'd2;  // fetch the first entry for the mode scan
    localparam logic [2:0] ST_MSCAN  = 3'd3;  // keep the best entry
    localparam logic [2:0] ST_DSTART = 3'd4;  // launch the share divide
    localparam logic [2:0] ST_DIV    = 3'd5;  // wait for the quotient
    localparam logic [2:0] ST_EMIT   = 3'd6;  // load the output register

    logic [2:0]            r_state, n_state;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [ENT_W-1:0]      r_entries, n_entries;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic                  r_ovf, n_ovf;
    maj_pkg::t_code        r_code, n_code;
    logic                  r_last, n_last;
    maj_pkg::t_code        r_best_code, n_best_code;
    logic [COUNT_BITS-1:0] r_best_cnt, n_best_cnt;

    logic                  r_ov, n_ov;
    maj_pkg::t_code        r_o_code;
    maj_pkg::t_out_cnt     r_o_mcnt, r_o_total;
    maj_pkg::t_share       r_o_share;
    logic                  r_o_ovf;

    // table memory ports
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [MEM_W-1:0]      mem_wd;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_ra;
    logic [MEM_W-1:0]      mem_rd;
    maj_pkg::t_code        q_code;
    logic [COUNT_BITS-1:0] q_cnt;

    // divider
    logic                  div_start;
    maj_pkg::t_div_stat    div_stat;
    logic [NUM_W-1:0]      div_quot;

    logic                  take;
    logic                  emit;
    logic                  tbl_full;
    logic                  at_last_ent;
    logic                  better;
    logic [WIDE_W-1:0]     best_w, total_w;
    maj_pkg::t_share       share;

    maj_mem #(
        .DEPTH  (DISTINCT_ENTRIES),
        .ADDR_W (ADDR_W),
        .WIDTH  (MEM_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_ra),
        .o_rd_data (mem_rd)
    );

    maj_div #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_best_cnt, {maj_pkg::FRAC_BITS{1'b0}}}),
        .i_den   (r_total),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign q_code = mem_rd[MEM_W-1:COUNT_BITS];
    assign q_cnt  = mem_rd[COUNT_BITS-1:0];

    assign i_item.ready = (r_state == ST_IDLE);
    assign take         = i_item.valid && (r_state == ST_IDLE);
    assign emit         = (r_state == ST_EMIT) && (!r_ov || o_result.ready);
    assign tbl_full     = (r_entries == ENT_W'(DISTINCT_ENTRIES));
    assign at_last_ent  = (ENT_W'(r_idx) == (r_entries - ENT_W'(1)));
    // strict greater count wins; equal count goes to the smaller code
    assign better       = (r_idx == '0) || (q_cnt > r_best_cnt) ||
                          ((q_cnt == r_best_cnt) && (q_code < r_best_code));
    assign div_start    = (r_state == ST_DSTART);

    // clamp internal counts to the 16-bit result fields
    assign best_w  = WIDE_W'(r_best_cnt);
    assign total_w = WIDE_W'(r_total);
    always_comb begin
        if (r_total == '0) begin
            share = '0;
        end else if (div_quot > NUM_W'(maj_pkg::SHARE_ONE)) begin
            share = maj_pkg::SHARE_ONE;
        end else begin
            share = div_quot[maj_pkg::SHARE_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_entries   = r_entries;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_code      = r_code;
        n_last      = r_last;
        n_best_code = r_best_code;
        n_best_cnt  = r_best_cnt;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = {r_code, COUNT_BITS'(1)};
        mem_re      = 1'b0;
        mem_ra      = r_idx + ADDR_W'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_code  = i_item.particle_code;
                    n_last  = i_item.last_item;
                    n_total = (r_total == COUNT_MAX) ? r_total : r_total + COUNT_BITS'(1);
                    n_idx   = '0;
                    if (r_entries == '0) begin
                        // empty table: first code goes straight into entry zero
                        mem_we    = 1'b1;
                        mem_wa    = '0;
                        mem_wd    = {i_item.particle_code, COUNT_BITS'(1)};
                        n_entries = ENT_W'(1);
                        n_state   = i_item.last_item ? ST_MSTART : ST_IDLE;
                    end else begin
                        mem_re  = 1'b1;
                        mem_ra  = '0;
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (q_code == r_code) begin
                    // hit: bump the count in place
                    mem_we  = 1'b1;
                    mem_wa  = r_idx;
                    mem_wd  = {q_code, (q_cnt == COUNT_MAX) ? q_cnt
                                                            : q_cnt + COUNT_BITS'(1)};
                    n_state = r_last ? ST_MSTART : ST_IDLE;
                end else if (at_last_ent) begin
                    // miss: append, or flag overflow when the table is full
                    if (tbl_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wa    = r_entries[ADDR_W-1:0];
                        n_entries = r_entries + ENT_W'(1);
                    end
                    n_state = r_last ? ST_MSTART : ST_IDLE;
                end else begin
                    // advance: fetch the next entry
                    mem_re = 1'b1;
                    n_idx  = r_idx + ADDR_W'(1);
                end
            end
            ST_MSTART: begin
                mem_re  = 1'b1;
                mem_ra  = '0;
                n_idx   = '0;
                n_state = ST_MSCAN;
            end
            ST_MSCAN: begin
                if (better) begin
                    n_best_code = q_code;
                    n_best_cnt  = q_cnt;
                end
                if (at_last_ent) begin
                    n_state = ST_DSTART;
                end else begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + ADDR_W'(1);
                end
            end
            ST_DSTART: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free, then drop the set
                if (emit) begin
                    n_entries = '0;
                    n_total   = '0;
                    n_ovf     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (emit) begin
            n_ov = 1'b1;
        end else if (o_result.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_entries <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_entries <= n_entries;
            r_total   <= n_total;
            r_ovf     <= n_ovf;
            r_ov      <= n_ov;
        end
        r_idx       <= n_idx;
        r_code      <= n_code;
        r_last      <= n_last;
        r_best_code <= n_best_code;
        r_best_cnt  <= n_best_cnt;
        if (emit) begin
            r_o_code  <= r_best_code;
            r_o_mcnt  <= (best_w > OUT_MAX) ? maj_pkg::t_out_cnt'('1)
                                            : best_w[maj_pkg::OUT_CNT_W-1:0];
            r_o_total <= (total_w > OUT_MAX) ? maj_pkg::t_out_cnt'('1)
                                             : total_w[maj_pkg::OUT_CNT_W-1:0];
            r_o_share <= share;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_result.valid          = r_ov;
    assign o_result.mode_code      = r_o_code;
    assign o_result.mode_count     = r_o_mcnt;
    assign o_result.total_count    = r_o_total;
    assign o_result.mode_share     = r_o_share;
    assign o_result.table_overflow = r_o_ovf;

    // Table never holds more entries than it has rows.
    `MAJ_ASSERT_NOW(a_entries_bound, 1'b1, r_entries <= ENT_W'(DISTINCT_ENTRIES))
    // The search only visits filled entries.
    `MAJ_ASSERT_NOW(a_cmp_in_range, r_state == ST_CMP, ENT_W'(r_idx) < r_entries)
    // The divider is never left running while beats are being taken.
    `MAJ_ASSERT_NOW(a_div_quiet, r_state == ST_IDLE, !div_stat.busy)
    // A shown result never has the mode above the total.
    `MAJ_ASSERT_NOW(a_mode_le_total, o_result.valid,
                    o_result.mode_count <= o_result.total_count)
    // Emitting a result empties the set.
    `MAJ_ASSERT_NEXT(a_set_cleared, emit, (r_entries == '0) && (r_total == '0) && !r_ovf)

endmodule

// File: hw/rtl/maj_mem.sv
// Identifier/count table: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module maj_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 41
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/maj_div.sv
// Restoring divider, one quotient bit per cycle, for the mode share.
// Depends on maj_pkg.
`timescale 1ns / 1ps

module maj_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output maj_pkg::t_div_stat o_stat,
    output logic [NUM_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DEN_W-1:0] r_rem,  n_rem;
    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0] r_den,  n_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_rem  = '0;
            n_quot = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_quot = {r_quot[NUM_W-2:0], fits};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// File: verif/majority_id_finder_tb.sv
// Self-checking testbench for majority_id_finder: identifier sets in, one mode result per set.
// Depends on maj_pkg, maj_if (maj_in_if, maj_out_if) and majority_id_finder.
`timescale 1ns / 1ps

module majority_id_finder_tb;

    localparam int ENTRIES        = 16;
    localparam int CNT_W          = 16;
    localparam int CODE_LIMIT     = 9999999;
    localparam int RANDOM_BEATS   = 1380;
    localparam int RUN_BEATS      = 20;
    localparam int GAP_LONG_MAX   = 40;
    localparam int STALL_LONG_MAX = 40;
    // member scan, mode scan, serial divide and output load of the last set
    localparam int TAIL_CYCLES    = 2 * ENTRIES + CNT_W + 40;

    typedef struct {
        maj_pkg::t_code code;
        logic           last;
        int unsigned    gap;
        logic           wait_idle;
    } t_hit_beat;

    typedef struct {
        maj_pkg::t_code    mode_code;
        maj_pkg::t_out_cnt mode_count;
        maj_pkg::t_out_cnt total_count;
        maj_pkg::t_share   mode_share;
        logic              table_overflow;
    } t_mode_result;

    logic clk;
    logic rst_n;

    maj_in_if  item_if ();
    maj_out_if result_if ();

    majority_id_finder #(
        .DISTINCT_ENTRIES(ENTRIES),
        .COUNT_BITS      (CNT_W)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    always #5 clk = ~clk;

    t_hit_beat    hits_pending[$];
    t_mode_result modes_due[$];
    t_hit_beat    head;
    t_mode_result want;

    // Mirror of the block's set state.
    maj_pkg::t_code   id_tab[ENTRIES];
    logic [CNT_W-1:0] hits_tab[ENTRIES];
    int               ids_used;
    logic [CNT_W-1:0] hits_total;
    logic             spilled;

    int          errors;
    longint      cycles;
    longint      cycle_limit;
    logic        beat_taken;
    int unsigned gap_left;
    logic        gap_done;
    int unsigned stall_left;
    logic        recv_calm;
    int unsigned recv_calm_left;
    logic        send_calm;
    int unsigned send_calm_left;
    int          n_beats;
    int          n_sets;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Count one identifier into the set; on the last one form the mode result and clear.
    task automatic tally_code(input maj_pkg::t_code code, input logic last);
        logic              found;
        maj_pkg::t_code    best_id;
        logic [CNT_W-1:0]  best_hits;
        logic [CNT_W+16:0] num;
        logic [CNT_W+16:0] share;
        longint unsigned   wide;
        t_mode_result      r;
        found = 1'b0;
        if (hits_total != '1) hits_total++;
        for (int k = 0; k < ids_used; k++) begin
            if (!found && id_tab[k] == code) begin
                if (hits_tab[k] != '1) hits_tab[k]++;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (ids_used < ENTRIES) begin
                id_tab[ids_used]   = code;
                hits_tab[ids_used] = 1;
                ids_used++;
            end else begin
                spilled = 1'b1;
            end
        end
        if (last) begin
            best_id   = '0;
            best_hits = '0;
            // strict greater-than keeps the first, and ties fall to the smaller identifier
            for (int k = 0; k < ids_used; k++) begin
                if (k == 0 || hits_tab[k] > best_hits ||
                    (hits_tab[k] == best_hits && id_tab[k] < best_id)) begin
                    best_id   = id_tab[k];
                    best_hits = hits_tab[k];
                end
            end
            num   = best_hits;
            num   = num << maj_pkg::FRAC_BITS;
            share = (hits_total != 0) ? num / hits_total : '0;
            if (share > maj_pkg::SHARE_ONE) share = maj_pkg::SHARE_ONE;
            r.mode_code      = best_id;
            wide             = best_hits;
            r.mode_count     = (wide > 65535) ? 16'hFFFF : maj_pkg::t_out_cnt'(wide);
            wide             = hits_total;
            r.total_count    = (wide > 65535) ? 16'hFFFF : maj_pkg::t_out_cnt'(wide);
            r.mode_share     = maj_pkg::t_share'(share);
            r.table_overflow = spilled;
            modes_due        = {modes_due, r};
            ids_used   = 0;
            hits_total = '0;
            spilled    = 1'b0;
        end
    endtask

    // Queue one beat; the gap in front of it comes from alternating calm and busy stretches.
    task automatic queue_hit(input maj_pkg::t_code code, input logic last,
                             input logic wait_idle);
        t_hit_beat   b;
        int unsigned r;
        if (send_calm_left == 0) begin
            send_calm      = ($urandom_range(0, 2) == 0);
            send_calm_left = $urandom_range(20, 80);
        end
        send_calm_left--;
        r = $urandom_range(0, 99);
        if (send_calm || r < 60) b.gap = 0;
        else if (r < 92)         b.gap = $urandom_range(1, 3);
        else                     b.gap = $urandom_range(10, GAP_LONG_MAX);
        b.code       = code;
        b.last       = last;
        b.wait_idle  = wait_idle;
        hits_pending = {hits_pending, b};
        n_beats++;
        if (last) n_sets++;
    endtask

    function automatic maj_pkg::t_code any_code();
        return maj_pkg::t_code'(int'($urandom_range(0, 2 * CODE_LIMIT)) - CODE_LIMIT);
    endfunction

    // Item driver: present beats at the falling edge, hold each until taken.
    always @(negedge clk) begin
        if (!rst_n) begin
            item_if.valid <= 1'b0;
        end else if (item_if.valid && !beat_taken) begin
            // hold the beat
        end else if (gap_left != 0) begin
            gap_left--;
            item_if.valid <= 1'b0;
        end else if (hits_pending.size() == 0 ||
                     (hits_pending[0].wait_idle && modes_due.size() != 0)) begin
            item_if.valid <= 1'b0;
        end else if (!gap_done && hits_pending[0].gap != 0) begin
            gap_left = hits_pending[0].gap - 1;
            gap_done = 1'b1;
            item_if.valid <= 1'b0;
        end else begin
            head     = hits_pending.pop_front();
            gap_done = 1'b0;
            item_if.valid         <= 1'b1;
            item_if.particle_code <= head.code;
            item_if.last_item     <= head.last;
        end
    end

    // Result sink: random stalls, with long stretches of steady ready in between.
    always @(negedge clk) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            result_if.ready <= 1'b0;
        end else begin
            if (recv_calm_left == 0) begin
                recv_calm      = ($urandom_range(0, 2) == 0);
                recv_calm_left = $urandom_range(50, 400);
            end
            recv_calm_left--;
            if (!recv_calm && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                          : $urandom_range(9, STALL_LONG_MAX);
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: check result beats first, then count the accepted item beat.
    always @(posedge clk) begin
        cycles++;
        if (cycles > cycle_limit) begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && result_if.valid && result_if.ready) begin
            if (modes_due.size() == 0) begin
                flag_mismatch($sformatf("result with none due: code %0d count %0d",
                                        result_if.mode_code, result_if.mode_count));
            end else begin
                want = modes_due.pop_front();
                if (result_if.mode_code !== want.mode_code ||
                    result_if.mode_count !== want.mode_count ||
                    result_if.total_count !== want.total_count ||
                    result_if.mode_share !== want.mode_share ||
                    result_if.table_overflow !== want.table_overflow)
                    flag_mismatch($sformatf(
                        "code %0d/%0d count %0d/%0d total %0d/%0d share %0d/%0d ovf %b/%b",
                        result_if.mode_code, want.mode_code,
                        result_if.mode_count, want.mode_count,
                        result_if.total_count, want.total_count,
                        result_if.mode_share, want.mode_share,
                        result_if.table_overflow, want.table_overflow));
            end
        end
        beat_taken = rst_n && item_if.valid && item_if.ready;
        if (beat_taken) tally_code(item_if.particle_code, item_if.last_item);
    end

    initial begin
        maj_pkg::t_code pool[$];
        int             len;
        int             n_ids;
        int             random_beats;
        int             base;
        int unsigned    r;
        logic           favor_first;
        logic           first;

        clk                      = 1'b0;
        rst_n                    = 1'b0;
        item_if.valid            = 1'b0;
        item_if.particle_code    = '0;
        item_if.last_item        = 1'b0;
        result_if.ready          = 1'b0;
        ids_used                 = 0;
        hits_total               = '0;
        spilled                  = 1'b0;
        errors                   = 0;
        cycles                   = 0;
        cycle_limit              = 64'h7FFF_FFFF_FFFF_FFFF;
        beat_taken               = 1'b0;
        gap_left                 = 0;
        gap_done                 = 1'b0;
        stall_left               = 0;
        recv_calm_left           = 0;
        send_calm_left           = 0;
        n_beats                  = 0;
        n_sets                   = 0;

        // Directed: lone item, the code limits +/-CODE_LIMIT tied at one hit each.
        queue_hit(maj_pkg::t_code'(0), 1'b1, 1'b0);
        queue_hit(maj_pkg::t_code'(CODE_LIMIT), 1'b0, 1'b0);
        queue_hit(maj_pkg::t_code'(-CODE_LIMIT), 1'b1, 1'b0);
        // Tie at two hits between a negative and a positive code.
        queue_hit(maj_pkg::t_code'(-1), 1'b0, 1'b0);
        queue_hit(maj_pkg::t_code'(5), 1'b0, 1'b0);
        queue_hit(maj_pkg::t_code'(5), 1'b0, 1'b0);
        queue_hit(maj_pkg::t_code'(-1), 1'b0, 1'b0);
        queue_hit(maj_pkg::t_code'(3), 1'b1, 1'b0);
        // One distinct code more than the table holds.
        for (int k = 0; k <= ENTRIES; k++)
            queue_hit(maj_pkg::t_code'(100 + k), (k == ENTRIES), 1'b0);

        // Run of one code, then a stray code closes the set.
        // Wait for every result first, so the sender pauses at least once.
        for (int k = 0; k < RUN_BEATS; k++)
            queue_hit(maj_pkg::t_code'(7), 1'b0, (k == 0));
        queue_hit(maj_pkg::t_code'(-3), 1'b1, 1'b0);

        // Random sets: mostly short, some long, some spilling past the table.
        random_beats = 0;
        first        = 1'b1;
        while (random_beats < RANDOM_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 12);
            else if (r < 95) len = $urandom_range(13, 40);
            else             len = $urandom_range(41, 90);
            if ($urandom_range(0, 99) < 15) begin
                n_ids = $urandom_range(ENTRIES + 1, ENTRIES + 8);
                len   = $urandom_range(n_ids, n_ids + 30);
            end else begin
                n_ids = $urandom_range(1, (len < 8) ? len : 8);
            end
            pool.delete();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // neighbors of one base, often straddling zero
                base = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) - 8
                                                   : int'($urandom_range(0, 2 * CODE_LIMIT - 16))
                                                     - CODE_LIMIT + 8;
                for (int k = 0; k < n_ids; k++)
                    pool = {pool, maj_pkg::t_code'(base + int'($urandom_range(0, 16)) - 8)};
            end else begin
                for (int k = 0; k < n_ids; k++) begin
                    case ($urandom_range(0, 19))
                        0:       pool = {pool, maj_pkg::t_code'(CODE_LIMIT)};
                        1:       pool = {pool, maj_pkg::t_code'(-CODE_LIMIT)};
                        default: pool = {pool, any_code()};
                    endcase
                end
            end
            favor_first = $urandom_range(0, 1);
            for (int k = 0; k < len; k++) begin
                r = (favor_first && $urandom_range(0, 2) == 0) ? 0
                                                               : $urandom_range(0, n_ids - 1);
                queue_hit(pool[r], (k == len - 1),
                          (k == 0) && (first || $urandom_range(0, 49) == 0));
            end
            first        = 1'b0;
            random_beats += len;
        end

        cycle_limit = 3 * (longint'(n_beats) * (GAP_LONG_MAX + ENTRIES + 2) +
                           longint'(n_sets) * (STALL_LONG_MAX + 2 * ENTRIES + CNT_W + 24))
                      + 1000;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every beat taken and every result seen, then let the pipe run dry.
        while (hits_pending.size() != 0 || item_if.valid || modes_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/maj_pkg.sv
hw/rtl/maj_if.sv
hw/rtl/maj_mem.sv
hw/rtl/maj_div.sv
hw/rtl/majority_id_finder.sv
verif/majority_id_finder_tb.sv
